[sv/sorted_array_priority_queue_unit_macros.svh]
// Assertion macros shared by the checker of the sorted priority queue.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Checked only out of reset.
`define SAPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SAPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/sapq_pkg.sv]
// Types and constants of the sorted priority queue.
package sapq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int STATUS_W     = 2;
  localparam int OUT_USED_W   = COUNT_W + 1 + VALUE_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_USED_W;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_NOTFOUND  = 2'd3
  } sapq_status_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } sapq_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } sapq_state_t;

  // controller -> datapath strobes
  typedef struct packed {
    logic capture;  // latch item and per-cell compare flags
    logic apply;    // update cells and load the result register
  } sapq_ctl_t;

endpackage

[sv/sapq_ctrl.sv]
// Controller: two-state sequencer and result valid flag.
module sapq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sapq_pkg::sapq_ctl_t ctl
);

  sapq_pkg::sapq_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sapq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    ctl.capture = 1'b0;
    ctl.apply   = 1'b0;
    unique case (state_r)
      sapq_pkg::ST_IDLE: begin
        // result slot must be free by the time APPLY writes it; nothing taken in reset
        in_tready = rst_n && (!out_valid_r || out_tready);
        if (in_tvalid && in_tready) begin
          ctl.capture = 1'b1;
          state_nxt   = sapq_pkg::ST_APPLY;
        end
      end
      sapq_pkg::ST_APPLY: begin
        ctl.apply = 1'b1;
        state_nxt = sapq_pkg::ST_IDLE;
      end
      default: state_nxt = sapq_pkg::ST_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (ctl.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

[sv/sapq_dpath.sv]
// Datapath: row of sorted cells with parallel compare and shift.
module sapq_dpath #(
  parameter int CAPACITY = sapq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sapq_pkg::sapq_ctl_t             ctl,
  input  logic [sapq_pkg::VALUE_W-1:0]    in_tdata,
  input  logic                            in_tuser,
  output logic [sapq_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [sapq_pkg::STATUS_W-1:0]   out_tuser
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [sapq_pkg::VALUE_W-1:0] entry_r   [CAPACITY];
  logic signed [sapq_pkg::VALUE_W-1:0] entry_nxt [CAPACITY];
  logic [CNT_W-1:0]                    count_r, count_nxt;

  logic                                op_r;
  logic signed [sapq_pkg::VALUE_W-1:0] val_r;
  logic [CAPACITY-1:0]                 lt_r, gt_r, lt_c, gt_c, eq_c, pos_m;
  logic                                found_r;

  logic [sapq_pkg::OUT_DATA_W-1:0]     out_tdata_r;
  logic [sapq_pkg::STATUS_W-1:0]       out_tuser_r;

  sapq_pkg::sapq_status_t              status;
  logic                                head_valid;
  logic signed [sapq_pkg::VALUE_W-1:0] head_value;

  // per-cell compare against the incoming value, masked to held entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_c[i] = (CNT_W'(i) < count_r) && (entry_r[i] < $signed(in_tdata));
      gt_c[i] = (CNT_W'(i) < count_r) && (entry_r[i] > $signed(in_tdata));
      eq_c[i] = (CNT_W'(i) < count_r) && (entry_r[i] == $signed(in_tdata));
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      op_r    <= in_tuser;
      val_r   <= $signed(in_tdata);
      lt_r    <= lt_c;
      gt_r    <= gt_c;
      found_r <= |eq_c;
    end
  end

  always_comb begin
    // insert point: first cell greater than the value, or first empty cell
    for (int i = 0; i < CAPACITY; i++) begin
      pos_m[i] = gt_r[i] || !(CNT_W'(i) < count_r);
    end

    for (int i = 0; i < CAPACITY; i++) begin
      entry_nxt[i] = entry_r[i];
    end
    count_nxt = count_r;
    status    = sapq_pkg::STATUS_OK;

    if (op_r == sapq_pkg::CMD_INSERT) begin
      if (count_r == CNT_W'(CAPACITY)) begin
        status = sapq_pkg::STATUS_OVERFLOW;
      end else begin
        entry_nxt[0] = pos_m[0] ? val_r : entry_r[0];
        for (int i = 1; i < CAPACITY; i++) begin
          if (pos_m[i-1]) begin
            entry_nxt[i] = entry_r[i-1];
          end else if (pos_m[i]) begin
            entry_nxt[i] = val_r;
          end
        end
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (count_r == '0) begin
        status = sapq_pkg::STATUS_UNDERFLOW;
      end else if (!found_r) begin
        status = sapq_pkg::STATUS_NOTFOUND;
      end else begin
        // equal entries are contiguous; first match sits after all smaller ones
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (!lt_r[i]) begin
            entry_nxt[i] = entry_r[i+1];
          end
        end
        count_nxt = count_r - CNT_W'(1);
      end
    end

    head_valid = (count_nxt != '0);
    head_value = head_valid ? entry_nxt[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entry_r[i] <= entry_nxt[i];
      end
      out_tuser_r <= status;
      out_tdata_r <= {{sapq_pkg::OUT_PAD_W{1'b0}}, head_value, head_valid,
                      sapq_pkg::COUNT_W'(count_nxt)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.apply) begin
      count_r <= count_nxt;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

[sv/sorted_array_priority_queue_unit.sv]
// Top level of the sorted-array priority queue.
//
//  channel  | direction | tdata                         | tuser
//  ---------+-----------+-------------------------------+-----------------
//  in_      | sink      | value[31:0]                   | command (0 ins)
//  out_     | source    | count, head_valid, head_value | status[1:0]
//
//  For each item, the accept edge latches it with a compare of
//  every held cell against the value, then the APPLY state shifts the cell
//  row and loads the result register. One item is in work at a time.
//  rst_n (synchronous) clears the fill count and the sequencer; cell
//  contents are not reset. A waiting result holds while out_tready is low;
//  a new item is taken once the result register will be free.
module sorted_array_priority_queue_unit #(
  parameter int CAPACITY = sapq_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_: item in
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sapq_pkg::VALUE_W-1:0]    in_tdata,   // [31:0] value (signed)
  input  logic                            in_tuser,   // [0] command
  // out_: result item
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sapq_pkg::OUT_DATA_W-1:0] out_tdata,  // [4:0] count, [5] head_valid,
                                                      // [37:6] head_value, [39:38] zero
  output logic [sapq_pkg::STATUS_W-1:0]   out_tuser   // [1:0] status
);

  sapq_pkg::sapq_ctl_t ctl;

  // sequencer: owns the handshakes
  sapq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  // cell row, compare flags and result register
  sapq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

[sv/sapq_checker.sv]
// Port-level checker of the sorted priority queue, with its bind.
`include "sorted_array_priority_queue_unit_macros.svh"

module sapq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sapq_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [sapq_pkg::STATUS_W-1:0]   out_tuser
);

  `SAPQ_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")
  `SAPQ_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result valid right after reset")
  `SAPQ_ASSERT(a_one_item, in_tvalid && in_tready |=> !in_tready, "second item taken while busy")
  `SAPQ_ASSERT(a_result_due, in_tvalid && in_tready |-> ##2 out_tvalid, "no result two cycles after item")
  `SAPQ_ASSERT(a_empty_head, out_tvalid && !out_tdata[5] |-> out_tdata[4:0] == 5'd0 && out_tdata[37:6] == 32'd0, "empty queue shows entries")

endmodule

bind sorted_array_priority_queue_unit sapq_checker u_sapq_checker (.*);

[test/sorted_array_priority_queue_unit_tb.sv]
// Self-checking testbench for the sorted-array priority queue: insert/delete items against a model.
module sorted_array_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sapq_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int CAPACITY       = CAPACITY_DEF;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_GAP        = 19;     // per-item idle draw, both sides
  localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
  localparam int SETTLE_CYCLES  = 20;     // settle time past the last result
  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no item moving on either side
  localparam int REPORT_LIMIT   = 10;

  localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

  // What one result item carries: status, fill after the item, and the head.
  typedef struct packed {
    sapq_status_t               status;
    logic [COUNT_W-1:0]         count;
    logic                       head_valid;
    logic signed [VALUE_W-1:0]  head_value;
  } head_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata = '0;
  logic                  in_tuser = CMD_INSERT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  // Mirror of the queue: ascending cells and how many are held.
  logic signed [VALUE_W-1:0] model_cells [CAPACITY];
  int                        model_fill = 0;

  head_report_t head_reports [$];   // reports awaited from the block, oldest first

  int error_count    = 0;
  int quiet_cycles   = 0;
  bit tx_idles       = 1'b1;        // sender draws gaps
  bit rx_idles       = 1'b1;        // receiver draws stalls
  bit hold_request   = 1'b0;        // ask the receiver for one long hold-off

  always #(CLK_PERIOD / 2) clk = ~clk;

  sorted_array_priority_queue_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Apply one command to the mirror and return the report it should give.
  // Inserts land after every entry <= value, so equal values stay in arrival
  // order; deletes take the lowest-indexed match and close the gap.
  function automatic head_report_t apply_queue_op(input sapq_cmd_t cmd,
                                                  input logic signed [VALUE_W-1:0] value);
    head_report_t rep;
    int pos;
    int k;
    rep.status = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (model_fill >= CAPACITY) begin
        rep.status = STATUS_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < model_fill && !(model_cells[pos] > value)) pos++;
        for (k = model_fill; k > pos; k--) model_cells[k] = model_cells[k-1];
        model_cells[pos] = value;
        model_fill++;
      end
    end else begin
      if (model_fill == 0) begin
        rep.status = STATUS_UNDERFLOW;
      end else begin
        pos = 0;
        while (pos < model_fill && model_cells[pos] != value) pos++;
        if (pos >= model_fill) begin
          rep.status = STATUS_NOTFOUND;
        end else begin
          for (k = pos; k + 1 < model_fill; k++) model_cells[k] = model_cells[k+1];
          model_fill--;
        end
      end
    end
    rep.count      = model_fill[COUNT_W-1:0];
    rep.head_valid = (model_fill != 0);
    rep.head_value = (model_fill != 0) ? model_cells[0] : '0;
    return rep;
  endfunction

  // Offer one item after a drawn gap; valid stays high after the accept so the
  // next call can follow straight on without a bubble.
  task automatic send_item(input sapq_cmd_t cmd, input logic [VALUE_W-1:0] value);
    int gap;
    gap = tx_idles ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = cmd;
    in_tdata  = value;
    in_tvalid = 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    head_reports.push_back(apply_queue_op(cmd, value));
  endtask

  // Sender pause: wait until every awaited report has come back.
  task automatic drain_reports();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (head_reports.size() != 0) @(posedge clk);
  endtask

  // Value mix for random items: mostly a narrow pool so duplicates and delete
  // hits are common, plus held entries, extremes and full-range noise.
  function automatic logic [VALUE_W-1:0] pick_value(input sapq_cmd_t cmd);
    int sel;
    sel = $urandom_range(0, 9);
    if (cmd == CMD_DELETE && model_fill != 0 && sel < 4)
      return model_cells[$urandom_range(0, model_fill - 1)];
    case (sel)
      7: return $urandom;
      8: begin
        case ($urandom_range(0, 3))
          0:       return VALUE_MIN;
          1:       return VALUE_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      9: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return 32'($signed($urandom_range(0, 15)) - 8);
    endcase
  endfunction

  // Delete on an empty queue: underflow, nothing changes.
  task automatic test_empty_delete();
    send_item(CMD_DELETE, VALUE_MIN);
  endtask

  // Fill to capacity with extremes, signs and duplicates, then overflow once.
  // 0, -1, min and max between them put every value bit through both levels.
  task automatic test_fill_and_overflow();
    logic [VALUE_W-1:0] seeds [CAPACITY];
    int i;
    seeds = '{VALUE_MAX, VALUE_MIN, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd5,
              32'd1, 32'hFFFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'd100,
              32'hFFFF_FF9C, 32'd7, VALUE_MAX, VALUE_MIN, 32'd3};
    for (i = 0; i < CAPACITY; i++) send_item(CMD_INSERT, seeds[i]);
    send_item(CMD_INSERT, 32'd42);    // full: overflow
  endtask

  // Absent value, a duplicate, the head and the tail.
  task automatic test_delete_cases();
    send_item(CMD_DELETE, 32'd12345);  // not found
    send_item(CMD_DELETE, 32'd5);      // first of two equal entries
    send_item(CMD_DELETE, VALUE_MIN);  // head
    send_item(CMD_DELETE, VALUE_MAX);  // tail
    send_item(CMD_DELETE, 32'd5);      // the remaining equal entry
  endtask

  // Receiver held off for a long stretch while the sender keeps offering, so
  // the result register fills and in_tready drops.
  task automatic test_backpressure();
    int i;
    drain_reports();
    tx_idles     = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 20; i++)
      send_item($urandom_range(0, 2) == 0 ? CMD_DELETE : CMD_INSERT,
                pick_value(CMD_INSERT));
    drain_reports();
    tx_idles = 1'b1;
  endtask

  // Random traffic in bursts with a changing insert bias, so the queue swings
  // between full and empty, and with idling switched per burst on each side.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int ins_pct;
    sapq_cmd_t cmd;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        default: ins_pct = 15;
      endcase
      tx_idles = ($urandom_range(0, 2) != 0);
      rx_idles = ($urandom_range(0, 2) != 0);
      burst    = $urandom_range(20, 60);
      repeat (burst) begin
        cmd = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        send_item(cmd, pick_value(cmd));
        sent++;
      end
    end
  endtask

  // Receiver: a drawn stall before each result item, plus the one long hold.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = rx_idles ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1 && !hold_request);
    end
  end

  // Every accepted result item against the oldest awaited report.
  always @(posedge clk) begin
    head_report_t want;
    head_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status     = sapq_status_t'(out_tuser);
      got.count      = out_tdata[COUNT_W-1:0];
      got.head_valid = out_tdata[COUNT_W];
      got.head_value = out_tdata[COUNT_W+1 +: VALUE_W];
      if (head_reports.size() == 0) begin
        if (error_count < REPORT_LIMIT)
          $display("%0t: result item with none awaited: status %0d count %0d head %0b/%0d",
                   $realtime, got.status, got.count, got.head_valid, got.head_value);
        error_count++;
      end else begin
        want = head_reports.pop_front();
        if (got !== want) begin
          if (error_count < REPORT_LIMIT)
            $display("%0t: mismatch: exp status %0d count %0d head %0b/%0d, got status %0d count %0d head %0b/%0d",
                     $realtime, want.status, want.count, want.head_valid, want.head_value,
                     got.status, got.count, got.head_valid, got.head_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long with no item moving on either channel ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_delete();
    test_fill_and_overflow();
    test_delete_cases();
    drain_reports();
    test_backpressure();
    test_random_traffic(910);

    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (head_reports.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sorted_array_priority_queue_unit.f]
+incdir+sv
sv/sapq_pkg.sv
sv/sapq_ctrl.sv
sv/sapq_dpath.sv
sv/sorted_array_priority_queue_unit.sv
sv/sapq_checker.sv
test/sorted_array_priority_queue_unit_tb.sv
